>>> rtl/core/sfir_pkg.sv
package sfir_pkg;

  localparam int unsigned HALF_ORDER_DEF = 500;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned COEF_IDX_W = 10;
  localparam int unsigned PROD_W     = SAMPLE_W + COEF_W;

  // Kind of an input item, carried on tuser.
  typedef enum logic {
    OP_COEF   = 1'b0,
    OP_SAMPLE = 1'b1
  } sfir_op_e;

  // Control that follows the memory read data into the multiply-accumulate unit.
  typedef struct packed {
    logic clear;  // start of a new sample: empty the accumulators
    logic vld;    // memory read data is valid this cycle
    logic live;   // the history slot holds a real sample, not pre-reset silence
  } sfir_mac_ctl_t;

endpackage

>>> rtl/core/sfir_ram.sv
module sfir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1001
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sfir_mac.sv
module sfir_mac import sfir_pkg::*; #(
  parameter int unsigned TAPS = 2 * HALF_ORDER_DEF + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sfir_mac_ctl_t              ctl_i,
  input  logic signed [COEF_W-1:0]   coef_i,
  input  logic signed [SAMPLE_W-1:0] left_i,
  input  logic signed [SAMPLE_W-1:0] right_i,
  output logic                       busy_o,
  output logic signed [SAMPLE_W-1:0] left_o,
  output logic signed [SAMPLE_W-1:0] right_o,
  output logic                       clip_o
);

  localparam int unsigned ACC_W  = PROD_W + $clog2(TAPS);
  localparam int unsigned FRAC_W = COEF_W - 1;
  localparam logic signed [ACC_W-1:0] HALF_UP = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] HALF_DN = HALF_UP - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO  = -SAT_HI - ACC_W'(1);

  logic                     prod_vld_q;
  logic signed [PROD_W-1:0] prod_l_q;
  logic signed [PROD_W-1:0] prod_r_q;
  logic signed [ACC_W-1:0]  acc_l_q;
  logic signed [ACC_W-1:0]  acc_r_q;
  logic [SAMPLE_W:0]        res_l;
  logic [SAMPLE_W:0]        res_r;

  // Rounds half away from zero: a negative sum takes a bias one short of a half,
  // so that the arithmetic shift (a floor) lands on the value away from zero.
  // Returns the clip flag above the saturated sample.
  function automatic logic [SAMPLE_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] r;
    logic [SAMPLE_W:0]       res;
    sum = acc + (acc[ACC_W-1] ? HALF_DN : HALF_UP);
    r   = sum >>> FRAC_W;
    if (r > SAT_HI) begin
      res = {1'b1, SAT_HI[SAMPLE_W-1:0]};
    end else if (r < SAT_LO) begin
      res = {1'b1, SAT_LO[SAMPLE_W-1:0]};
    end else begin
      res = {1'b0, r[SAMPLE_W-1:0]};
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.live) begin
      prod_l_q <= PROD_W'(coef_i) * PROD_W'(left_i);
      prod_r_q <= PROD_W'(coef_i) * PROD_W'(right_i);
    end else begin
      prod_l_q <= '0;
      prod_r_q <= '0;
    end
    if (ctl_i.clear) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (prod_vld_q) begin
      acc_l_q <= acc_l_q + ACC_W'(prod_l_q);
      acc_r_q <= acc_r_q + ACC_W'(prod_r_q);
    end
  end

  assign res_l   = round_sat(acc_l_q);
  assign res_r   = round_sat(acc_r_q);
  assign busy_o  = prod_vld_q;
  assign left_o  = res_l[SAMPLE_W-1:0];
  assign right_o = res_r[SAMPLE_W-1:0];
  assign clip_o  = res_l[SAMPLE_W] | res_r[SAMPLE_W];

endmodule

>>> rtl/core/stereo_fir_filter_core.sv
// A coefficient write keeps the block idle: the next item is taken in the following cycle.
// A sample pair makes one read of the shared coefficient and history memories per tap,
// then passes through the read register, the product registers and the accumulators;
// no new item is taken until its result is loaded into the output register. Reset
// clears the control and the fill count, so history reads as zero; coefficients are
// undefined until written and there is no clearing pass.
module stereo_fir_filter_core import sfir_pkg::*; #(
  parameter int unsigned HALF_ORDER = HALF_ORDER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // coef_index[9:0], coef_value[25:10], left_in[41:26], right_in[57:42], zero[63:58]
  input  logic [63:0] s_axis_tdata_i,
  // operation[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // left_out[15:0], right_out[31:16]
  output logic [31:0] m_axis_tdata_o,
  // clipped[0]
  output logic        m_axis_tuser_o
);

  localparam int unsigned TAPS = 2 * HALF_ORDER + 1;
  localparam int unsigned AW   = $clog2(TAPS);
  localparam logic [AW-1:0] LAST_POS  = AW'(TAPS - 1);
  localparam logic [AW-1:0] FILL_FULL = AW'(TAPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e                      state_q;
  logic [AW-1:0]               newest_q;
  logic [AW-1:0]               newest_d;
  logic [AW-1:0]               rd_pos_q;
  logic [AW-1:0]               k_q;
  logic [AW-1:0]               fill_q;
  logic                        rd_vld_q;
  logic                        rd_live_q;
  logic                        m_tvalid_q;
  logic [SAMPLE_W-1:0]         out_l_q;
  logic [SAMPLE_W-1:0]         out_r_q;
  logic                        out_clip_q;

  sfir_op_e                    op;
  logic [COEF_IDX_W-1:0]       coef_index;
  logic [COEF_W-1:0]           coef_value;
  logic [SAMPLE_W-1:0]         left_in;
  logic [SAMPLE_W-1:0]         right_in;
  logic                        in_fire;
  logic                        coef_we;
  logic                        hist_we;
  logic                        out_free;
  logic                        out_load;
  logic [COEF_W-1:0]           coef_rd;
  logic [2*SAMPLE_W-1:0]       hist_rd;
  sfir_mac_ctl_t               mac_ctl;
  logic                        mac_busy;
  logic signed [SAMPLE_W-1:0]  mac_l;
  logic signed [SAMPLE_W-1:0]  mac_r;
  logic                        mac_clip;

  assign op         = sfir_op_e'(s_axis_tuser_i);
  assign coef_index = s_axis_tdata_i[9:0];
  assign coef_value = s_axis_tdata_i[25:10];
  assign left_in    = s_axis_tdata_i[41:26];
  assign right_in   = s_axis_tdata_i[57:42];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign coef_we  = in_fire && (op == OP_COEF) && (32'(coef_index) < 32'(TAPS));
  assign hist_we  = in_fire && (op == OP_SAMPLE);
  assign newest_d = (newest_q == LAST_POS) ? '0 : newest_q + AW'(1);
  assign out_free = !m_tvalid_q || m_axis_tready_i;
  assign out_load = (state_q == ST_DRAIN) && !rd_vld_q && !mac_busy && out_free;

  sfir_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (AW'(coef_index)),
    .wdata_i (coef_value),
    .raddr_i (k_q),
    .rdata_o (coef_rd)
  );

  // The new pair is written at acceptance; reads start in the following cycle, so no
  // read ever meets a write to the same slot.
  sfir_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (newest_d),
    .wdata_i ({right_in, left_in}),
    .raddr_i (rd_pos_q),
    .rdata_o (hist_rd)
  );

  assign mac_ctl.clear = hist_we;
  assign mac_ctl.vld   = rd_vld_q;
  assign mac_ctl.live  = rd_live_q;

  sfir_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .coef_i  (coef_rd),
    .left_i  (hist_rd[SAMPLE_W-1:0]),
    .right_i (hist_rd[2*SAMPLE_W-1:SAMPLE_W]),
    .busy_o  (mac_busy),
    .left_o  (mac_l),
    .right_o (mac_r),
    .clip_o  (mac_clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      newest_q   <= '0;
      rd_pos_q   <= '0;
      k_q        <= '0;
      fill_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_live_q  <= 1'b0;
      m_tvalid_q <= 1'b0;
      out_l_q    <= '0;
      out_r_q    <= '0;
      out_clip_q <= 1'b0;
    end else begin
      rd_vld_q  <= (state_q == ST_RUN);
      // Taps reaching back before the first sample after reset see silence.
      rd_live_q <= (k_q < fill_q);
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tvalid_q && m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (hist_we) begin
            newest_q <= newest_d;
            rd_pos_q <= newest_d;
            k_q      <= '0;
            fill_q   <= (fill_q == FILL_FULL) ? fill_q : fill_q + AW'(1);
            state_q  <= ST_RUN;
          end
        end
        ST_RUN: begin
          k_q      <= k_q + AW'(1);
          rd_pos_q <= (rd_pos_q == '0) ? LAST_POS : rd_pos_q - AW'(1);
          if (k_q == LAST_POS) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            out_l_q    <= mac_l;
            out_r_q    <= mac_r;
            out_clip_q <= mac_clip;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = {out_r_q, out_l_q};
  assign m_axis_tuser_o  = out_clip_q;

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!rd_vld_q && !mac_busy))
    else $error("multiply-accumulate pipeline not empty while idle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("fill count beyond tap count");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (newest_q <= LAST_POS) && (rd_pos_q <= LAST_POS))
    else $error("history position out of range");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |=> ((state_q == ST_RUN) && (k_q == '0) && (rd_pos_q == newest_q)))
    else $error("tap sweep does not start at the newest sample");

endmodule

>>> sim/tb_stereo_fir_filter_core.sv
module tb_stereo_fir_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sfir_pkg::*;

  localparam int unsigned TAPS        = 2 * HALF_ORDER_DEF + 1;
  localparam int unsigned HOLD_CYCLES = 6000;
  localparam int unsigned TAIL_CYCLES = 2 * HALF_ORDER_DEF + 20;
  localparam int unsigned PHASE_ITEMS = 197;

  // Tracks the taps and the sample history, works out each filtered pair
  // and compares the pairs that leave the block with that prediction.
  class fir_scoreboard;
    typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                clipped;
    } pcm_pair_t;

    logic signed [SAMPLE_W-1:0] left_hist  [TAPS];
    logic signed [SAMPLE_W-1:0] right_hist [TAPS];
    logic signed [COEF_W-1:0]   taps       [TAPS];
    int unsigned                newest;
    pcm_pair_t                  pending_pairs[$];
    int                         errors;

    function new();
      foreach (left_hist[k]) begin
        left_hist[k]  = '0;
        right_hist[k] = '0;
        taps[k]       = '0;
      end
      newest = 0;
      errors = 0;
    endfunction

    // Q.15 sum to PCM: round half away from zero, then saturate.
    function logic [SAMPLE_W-1:0] round_to_pcm(longint acc, inout logic clip);
      longint q;
      if (acc >= 0) q = (acc + 16384) >>> 15;
      else q = -((-acc + 16384) >>> 15);
      if (q > 32767) begin
        clip = 1'b1;
        return 16'h7fff;
      end
      if (q < -32768) begin
        clip = 1'b1;
        return 16'h8000;
      end
      return q[SAMPLE_W-1:0];
    endfunction

    function void note_input(sfir_op_e op, logic [63:0] data);
      logic [COEF_IDX_W-1:0] idx;
      longint                acc_l;
      longint                acc_r;
      int unsigned           pos;
      logic                  clip;
      pcm_pair_t             pair;
      idx = data[9:0];
      if (op == OP_COEF) begin
        // Indexes past the last tap are dropped by the block.
        if (idx < TAPS) taps[idx] = data[25:10];
        return;
      end
      newest = (newest + 1) % TAPS;
      left_hist[newest]  = data[41:26];
      right_hist[newest] = data[57:42];
      acc_l = 0;
      acc_r = 0;
      pos   = newest;
      for (int k = 0; k < TAPS; k++) begin
        acc_l += longint'(taps[k]) * longint'(left_hist[pos]);
        acc_r += longint'(taps[k]) * longint'(right_hist[pos]);
        pos = (pos == 0) ? TAPS - 1 : pos - 1;
      end
      clip         = 1'b0;
      pair.left    = round_to_pcm(acc_l, clip);
      pair.right   = round_to_pcm(acc_r, clip);
      pair.clipped = clip;
      pending_pairs.push_back(pair);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t ns: %s got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] data, logic clipped);
      pcm_pair_t want;
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected item, tdata", data, '0);
        return;
      end
      want = pending_pairs.pop_front();
      if (data[15:0] !== want.left) report_mismatch("left_out", data[15:0], want.left);
      if (data[31:16] !== want.right) report_mismatch("right_out", data[31:16], want.right);
      if (clipped !== want.clipped) report_mismatch("clipped", clipped, want.clipped);
    endtask
  endclass

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  bit            hold_req      = 1'b0;
  int unsigned   hold_count    = 0;
  fir_scoreboard sb;

  stereo_fir_filter_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) sb.note_input(sfir_op_e'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) begin
          hold_req   = 1'b0;
          hold_count = 0;
        end
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [15:0] random_pcm();
    case ($urandom_range(19))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4, 5, 6: return 16'(int'($urandom_range(511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(sfir_op_e op, logic [9:0] idx, logic [15:0] coef,
                           logic [15:0] left, logic [15:0] right);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, right, left, coef, idx};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [9:0]  idx;
    logic [15:0] coef;
    int unsigned mode;
    int unsigned tail;

    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 18;
    recv_idle_pct = 83;
    @(negedge clk_i);

    // Every tap must hold a value before the first sample pair is sent.
    for (int k = 0; k < TAPS; k++) begin
      send_item(OP_COEF, 10'(k), 16'h0000, 16'($urandom), 16'($urandom));
    end

    // A gain of one half makes odd samples land exactly on the rounding midpoint.
    send_item(OP_COEF, 10'd0, 16'h4000, 16'($urandom), 16'($urandom));
    send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'h0001, 16'hffff);
    send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'h0003, 16'hfffd);
    send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'h7fff, 16'h8000);
    // Minus one times the most negative sample overflows.
    send_item(OP_COEF, 10'd0, 16'h8000, 16'($urandom), 16'($urandom));
    send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'h8000, 16'h7fff);
    // Indexes past the last tap must leave the taps untouched.
    send_item(OP_COEF, 10'd1023, 16'h7fff, 16'($urandom), 16'($urandom));
    send_item(OP_COEF, 10'(TAPS), 16'h7fff, 16'($urandom), 16'($urandom));
    send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'h1234, 16'hedcb);
    send_item(OP_COEF, 10'(TAPS - 1), 16'h7fff, 16'($urandom), 16'($urandom));
    send_item(OP_COEF, 10'd1, 16'h7fff, 16'($urandom), 16'($urandom));
    send_item(OP_COEF, 10'd0, 16'h7fff, 16'($urandom), 16'($urandom));
    // Full-scale taps 0 and 1 on full-scale input saturate both ways.
    send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'h8000, 16'h7fff);
    send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'h8000, 16'h7fff);
    send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), 16'hffff, 16'h0001);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 18;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
        default: ;
      endcase
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < 60) begin
          // Large taps only go to the first few positions, which are rewritten
          // often, so that not every output ends up saturated.
          idx  = $urandom_range(1) ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
          mode = $urandom_range(9);
          if (idx < 16 && mode < 3) begin
            coef = (mode == 0) ? 16'h7fff : (mode == 1) ? 16'h8000 : 16'($urandom);
          end else begin
            coef = 16'(int'($urandom_range(128)) - 64);
          end
          send_item(OP_COEF, idx, coef, 16'($urandom), 16'($urandom));
        end else begin
          send_item(OP_SAMPLE, 10'($urandom), 16'($urandom), random_pcm(), random_pcm());
        end
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending_pairs.size() != 0) @(posedge clk_i);
    for (tail = 0; tail < TAIL_CYCLES; tail++) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_pairs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
